[sv/gcd_pkg.sv]
// Shared CORDIC word width, gain, arctangent constants and register map.
package gcd_pkg;

    localparam int CW = 34;

    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

    localparam logic signed [CW-1:0] ATAN_TAB [10] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
        34'sd33543515,  34'sd16775850,  34'sd8388437,   34'sd4194282,   34'sd2097149
    };

    // config register indexes
    typedef enum logic [3:0] {
        REG_BODY_RADIUS = 4'd0,
        REG_INCL_ALT    = 4'd1
    } cfg_reg_t;

    // atan(2^-i) in Q30, truncated
    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] r;
        if (i < 10) begin
            r = ATAN_TAB[i];
        end else if (i <= 30) begin
            r = CW'((64'sd1 <<< (30 - i)) - 64'sd1);
        end else begin
            r = '0;
        end
        return r;
    endfunction

endpackage

[sv/gcd_cordic.sv]
// Pipelined CORDIC, one iteration per stage, rotation or vectoring mode.
module gcd_cordic
    import gcd_pkg::*;
#(
    parameter int STEPS  = 32,
    parameter int LANES  = 4,
    parameter int SIDE_W = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  vec_mode,
    input  logic                  in_valid,
    input  logic [SIDE_W-1:0]     in_side,
    input  logic signed [CW-1:0]  in_x [LANES],
    input  logic signed [CW-1:0]  in_y [LANES],
    input  logic signed [CW-1:0]  in_z [LANES],
    output logic                  out_valid,
    output logic [SIDE_W-1:0]     out_side,
    output logic signed [CW-1:0]  out_x [LANES],
    output logic signed [CW-1:0]  out_y [LANES],
    output logic signed [CW-1:0]  out_z [LANES]
);

    logic [STEPS-1:0]      valid_reg;
    logic [SIDE_W-1:0]     side_reg [STEPS];
    logic signed [CW-1:0]  x_reg  [LANES][STEPS];
    logic signed [CW-1:0]  y_reg  [LANES][STEPS];
    logic signed [CW-1:0]  z_reg  [LANES][STEPS];
    logic signed [CW-1:0]  x_next [LANES][STEPS];
    logic signed [CW-1:0]  y_next [LANES][STEPS];
    logic signed [CW-1:0]  z_next [LANES][STEPS];

    // every stage works on its own item
    always_comb begin
        logic signed [CW-1:0] xi, yi, zi, xs, ys, at;
        logic pos;
        for (int l = 0; l < LANES; l++) begin
            for (int g = 0; g < STEPS; g++) begin
                if (g == 0) begin
                    xi = in_x[l];
                    yi = in_y[l];
                    zi = in_z[l];
                end else begin
                    xi = x_reg[l][g-1];
                    yi = y_reg[l][g-1];
                    zi = z_reg[l][g-1];
                end
                xs = xi >>> g;
                ys = yi >>> g;
                at = atan_q30(g);
                if (vec_mode) begin
                    pos = !(yi > 0);
                end else begin
                    pos = !zi[CW-1];
                end
                if (pos) begin
                    x_next[l][g] = xi - ys;
                    y_next[l][g] = yi + xs;
                    z_next[l][g] = zi - at;
                end else begin
                    x_next[l][g] = xi + ys;
                    y_next[l][g] = yi - xs;
                    z_next[l][g] = zi + at;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int k = 1; k < STEPS; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int l = 0; l < LANES; l++) begin
                for (int g = 0; g < STEPS; g++) begin
                    x_reg[l][g] <= x_next[l][g];
                    y_reg[l][g] <= y_next[l][g];
                    z_reg[l][g] <= z_next[l][g];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            out_x[l] = x_reg[l][STEPS-1];
            out_y[l] = y_reg[l][STEPS-1];
            out_z[l] = z_reg[l][STEPS-1];
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

[sv/gcd_isqrt.sv]
// Pipelined digit-by-digit integer square root, one result bit per stage.
module gcd_isqrt
    import gcd_pkg::*;
#(
    parameter int ROOT_W = 32,
    parameter int LANES  = 2,
    parameter int SIDE_W = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [SIDE_W-1:0]     in_side,
    input  logic [2*ROOT_W-1:0]   in_n [LANES],
    output logic                  out_valid,
    output logic [SIDE_W-1:0]     out_side,
    output logic [ROOT_W-1:0]     out_root [LANES]
);

    localparam int NW = 2 * ROOT_W;

    logic [ROOT_W-1:0]  valid_reg;
    logic [SIDE_W-1:0]  side_reg [ROOT_W];
    logic [NW-1:0]      n_reg    [LANES][ROOT_W];
    logic [NW-1:0]      res_reg  [LANES][ROOT_W];
    logic [NW-1:0]      n_next   [LANES][ROOT_W];
    logic [NW-1:0]      res_next [LANES][ROOT_W];

    always_comb begin
        logic [NW-1:0] ni, ri, bt, t;
        for (int l = 0; l < LANES; l++) begin
            for (int g = 0; g < ROOT_W; g++) begin
                if (g == 0) begin
                    ni = in_n[l];
                    ri = '0;
                end else begin
                    ni = n_reg[l][g-1];
                    ri = res_reg[l][g-1];
                end
                bt = NW'(1) << (NW - 2 - 2 * g);
                t  = ri + bt;
                if (ni >= t) begin
                    n_next[l][g]   = ni - t;
                    res_next[l][g] = (ri >> 1) + bt;
                end else begin
                    n_next[l][g]   = ni;
                    res_next[l][g] = ri >> 1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[ROOT_W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int k = 1; k < ROOT_W; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int l = 0; l < LANES; l++) begin
                for (int g = 0; g < ROOT_W; g++) begin
                    n_reg[l][g]   <= n_next[l][g];
                    res_reg[l][g] <= res_next[l][g];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            out_root[l] = res_reg[l][ROOT_W-1][ROOT_W-1:0];
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

[sv/great_circle_distance_top.sv]
// Haversine great-circle distance pipeline, top level.
//
//  channel | ports                                  | direction | accepted when
//  --------+----------------------------------------+-----------+-----------------------
//  input   | s_valid s_ready s_from_* s_to_*        | in        | s_valid & s_ready
//  result  | m_valid m_ready m_distance_mm          | out       | m_valid & m_ready
//  config  | cfg_valid cfg_ready cfg_index cfg_data | in        | cfg_valid & cfg_ready
//
// One item per cycle while the skid register is empty. Results pass through the two
// CORDIC pipelines, the 32-stage root and the 44-stage altitude root.
// Reset is synchronous, active low; it clears valid bits and loads the default
// radius (6371000 m) with altitude off.
// All stages advance together while the skid register is empty; a stalled result
// parks one item in the skid, and s_ready drops only while the skid is full.
module great_circle_distance_top
    import gcd_pkg::*;
#(
    parameter int CORDIC_STEPS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [29:0] s_from_lat_mas,
    input  logic signed [30:0] s_from_lon_mas,
    input  logic signed [30:0] s_from_alt_mm,
    input  logic signed [29:0] s_to_lat_mas,
    input  logic signed [30:0] s_to_lon_mas,
    input  logic signed [30:0] s_to_alt_mm,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [41:0]        m_distance_mm,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam logic signed [33:0] MAS_QUARTER = 34'sd324000000;
    localparam logic signed [33:0] MAS_HALF    = 34'sd648000000;
    localparam logic signed [33:0] MAS_TURN    = 34'sd1296000000;
    localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
    localparam logic [63:0] MAS_TO_RAD_W = (PI_Q60 + 64'd324000000) / 64'd648000000;
    localparam logic [32:0] MAS_TO_RAD   = MAS_TO_RAD_W[32:0];
    localparam logic [30:0] ONE_Q30      = 31'd1073741824;
    localparam logic [43:0] DIST_MAX     = 44'd4000000000000;

    // reduce a longitude or latitude difference into [-180, 180) degrees
    function automatic logic signed [31:0] wrap_turn(input logic signed [31:0] d);
        logic signed [33:0] e, r;
        e = 34'(d);
        if (e >= MAS_HALF) begin
            r = e - MAS_TURN;
            if (r >= MAS_HALF) r = r - MAS_TURN;
        end else if (e < -MAS_HALF) begin
            r = e + MAS_TURN;
            if (r < -MAS_HALF) r = r + MAS_TURN;
        end else begin
            r = e;
        end
        return 32'(r);
    endfunction

    function automatic logic [31:0] mag32(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] a;
        a = v[CW-1] ? -v : v;
        return a[31:0];
    endfunction

    // mas magnitude times pi/648e6, rounded; half selects the extra halving
    function automatic logic signed [CW-1:0] to_rad(input logic [62:0] p, input logic neg,
                                                    input logic half);
        logic [63:0] s;
        logic [31:0] r;
        logic signed [CW-1:0] z;
        if (half) begin
            s = 64'(p) + (64'd1 << 30);
            r = s[62:31];
        end else begin
            s = 64'(p) + (64'd1 << 29);
            r = s[61:30];
        end
        z = signed'(CW'(r));
        return neg ? -z : z;
    endfunction

    // ---------------- configuration ----------------
    logic [29:0] radius_reg;
    logic        incl_alt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg   <= 30'd6371000;
            incl_alt_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BODY_RADIUS: radius_reg   <= cfg_data[29:0];
                REG_INCL_ALT:    incl_alt_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic        en;
    logic        skid_valid_reg, skid_valid_next;
    logic [41:0] skid_dist_reg, skid_dist_next;
    logic        m_valid_reg, m_valid_next;
    logic [41:0] m_dist_reg, m_dist_next;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // ---------------- stage A: differences ----------------
    logic               va_reg;
    logic signed [29:0] lat1_a_reg, lat2_a_reg;
    logic signed [31:0] dlat_a_reg, dlon_a_reg;
    logic [31:0]        dalt_a_reg;
    logic signed [31:0] dalt_s;

    assign dalt_s = 32'(s_to_alt_mm) - 32'(s_from_alt_mm);

    always_ff @(posedge aclk) begin
        if (!aresetn) va_reg <= 1'b0;
        else if (en) va_reg <= s_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lat1_a_reg <= s_from_lat_mas;
            lat2_a_reg <= s_to_lat_mas;
            dlat_a_reg <= 32'(s_to_lat_mas) - 32'(s_from_lat_mas);
            dlon_a_reg <= 32'(s_to_lon_mas) - 32'(s_from_lon_mas);
            dalt_a_reg <= dalt_s[31] ? 32'(-dalt_s) : 32'(dalt_s);
        end
    end

    // ---------------- stage B: wrap and fold ----------------
    logic               vb_reg;
    logic [29:0]        mag_b_reg [4];
    logic               neg_b_reg [4];
    logic [31:0]        dalt_b_reg;
    logic [29:0]        mag_b_next [4];
    logic               neg_b_next [4];
    logic [31:0]        dalt_b_next_w;

    assign dalt_b_next_w = dalt_a_reg;

    always_comb begin
        logic signed [31:0] w0, w1, lt;
        logic [29:0] m;
        w0 = wrap_turn(dlat_a_reg);
        w1 = wrap_turn(dlon_a_reg);
        mag_b_next[0] = w0[31] ? 30'(-w0) : 30'(w0);
        neg_b_next[0] = w0[31];
        mag_b_next[1] = w1[31] ? 30'(-w1) : 30'(w1);
        neg_b_next[1] = w1[31];
        for (int k = 0; k < 2; k++) begin
            lt = (k == 0) ? 32'(lat1_a_reg) : 32'(lat2_a_reg);
            m  = lt[31] ? 30'(-lt) : 30'(lt);
            // past the pole: cos(lat) = -cos(180 deg - |lat|)
            if (34'(m) > MAS_QUARTER) begin
                mag_b_next[k+2] = 30'(MAS_HALF) - m;
                neg_b_next[k+2] = 1'b1;
            end else begin
                mag_b_next[k+2] = m;
                neg_b_next[k+2] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vb_reg <= 1'b0;
        else if (en) vb_reg <= va_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                mag_b_reg[k] <= mag_b_next[k];
                neg_b_reg[k] <= neg_b_next[k];
            end
            dalt_b_reg <= dalt_b_next_w;
        end
    end

    // ---------------- stage C: angle scaling product ----------------
    logic        vc_reg;
    logic [62:0] prod_c_reg [4];
    logic        neg_c_reg  [4];
    logic [31:0] dalt_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vc_reg <= 1'b0;
        else if (en) vc_reg <= vb_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                prod_c_reg[k] <= 63'(mag_b_reg[k]) * 63'(MAS_TO_RAD);
                neg_c_reg[k]  <= neg_b_reg[k];
            end
            dalt_c_reg <= dalt_b_reg;
        end
    end

    // ---------------- stage D: rounding to Q30 radians ----------------
    logic                 vd_reg;
    logic signed [CW-1:0] z_d_reg [4];
    logic                 cneg_d_reg [2];
    logic [31:0]          dalt_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vd_reg <= 1'b0;
        else if (en) vd_reg <= vc_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // differences are halved, latitudes folded to non-negative angles
            z_d_reg[0]    <= to_rad(prod_c_reg[0], neg_c_reg[0], 1'b1);
            z_d_reg[1]    <= to_rad(prod_c_reg[1], neg_c_reg[1], 1'b1);
            z_d_reg[2]    <= to_rad(prod_c_reg[2], 1'b0, 1'b0);
            z_d_reg[3]    <= to_rad(prod_c_reg[3], 1'b0, 1'b0);
            cneg_d_reg[0] <= neg_c_reg[2];
            cneg_d_reg[1] <= neg_c_reg[3];
            dalt_d_reg    <= dalt_c_reg;
        end
    end

    // ---------------- rotation CORDIC: sin of half diffs, cos of lats ----------------
    logic signed [CW-1:0] rot_x_in [4], rot_y_in [4], rot_x_out [4], rot_y_out [4];
    logic                 rot_valid;
    logic [33:0]          rot_side;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rot_x_in[k] = GAIN_Q30;
            rot_y_in[k] = '0;
        end
    end

    gcd_cordic #(
        .STEPS  (CORDIC_STEPS),
        .LANES  (4),
        .SIDE_W (34)
    ) u_rot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .vec_mode  (1'b0),
        .in_valid  (vd_reg),
        .in_side   ({dalt_d_reg, cneg_d_reg[0], cneg_d_reg[1]}),
        .in_x      (rot_x_in),
        .in_y      (rot_y_in),
        .in_z      (z_d_reg),
        .out_valid (rot_valid),
        .out_side  (rot_side),
        .out_x     (rot_x_out),
        .out_y     (rot_y_out),
        .out_z     ()
    );

    // ---------------- stage E: squares and cosine product ----------------
    logic        ve_reg;
    logic [63:0] sl_e_reg, so_e_reg, cc_e_reg;
    logic        ccneg_e_reg;
    logic [31:0] dalt_e_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) ve_reg <= 1'b0;
        else if (en) ve_reg <= rot_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sl_e_reg    <= 64'(mag32(rot_y_out[0])) * 64'(mag32(rot_y_out[0]));
            so_e_reg    <= 64'(mag32(rot_y_out[1])) * 64'(mag32(rot_y_out[1]));
            cc_e_reg    <= 64'(mag32(rot_x_out[2])) * 64'(mag32(rot_x_out[3]));
            ccneg_e_reg <= rot_x_out[2][CW-1] ^ rot_side[1] ^ rot_x_out[3][CW-1] ^ rot_side[0];
            dalt_e_reg  <= rot_side[33:2];
        end
    end

    // ---------------- stage F: Q30 rounding ----------------
    logic        vf_reg;
    logic [31:0] sl_f_reg, so_f_reg, cc_f_reg;
    logic        ccneg_f_reg;
    logic [31:0] dalt_f_reg;
    logic [63:0] sl_r, so_r, cc_r;

    assign sl_r = sl_e_reg + (64'd1 << 29);
    assign so_r = so_e_reg + (64'd1 << 29);
    assign cc_r = cc_e_reg + (64'd1 << 29);

    always_ff @(posedge aclk) begin
        if (!aresetn) vf_reg <= 1'b0;
        else if (en) vf_reg <= ve_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sl_f_reg    <= sl_r[61:30];
            so_f_reg    <= so_r[61:30];
            cc_f_reg    <= cc_r[61:30];
            ccneg_f_reg <= ccneg_e_reg;
            dalt_f_reg  <= dalt_e_reg;
        end
    end

    // ---------------- stage G: cos product times sin^2 of half dlon ----------------
    logic        vg_reg;
    logic [63:0] t_g_reg;
    logic [31:0] sl_g_reg;
    logic        ccneg_g_reg;
    logic [31:0] dalt_g_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vg_reg <= 1'b0;
        else if (en) vg_reg <= vf_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_g_reg     <= 64'(cc_f_reg) * 64'(so_f_reg);
            sl_g_reg    <= sl_f_reg;
            ccneg_g_reg <= ccneg_f_reg;
            dalt_g_reg  <= dalt_f_reg;
        end
    end

    // ---------------- stage H: a, clamped to [0, 1] ----------------
    logic               vh_reg;
    logic [30:0]        a_h_reg;
    logic [31:0]        dalt_h_reg;
    logic [63:0]        t_r;
    logic signed [35:0] a_sum;
    logic [30:0]        a_h_next;

    always_comb begin
        logic signed [35:0] tt;
        t_r   = t_g_reg + (64'd1 << 29);
        tt    = signed'(36'(t_r[63:30]));
        a_sum = signed'(36'(sl_g_reg)) + (ccneg_g_reg ? -tt : tt);
        if (a_sum < 0) begin
            a_h_next = '0;
        end else if (a_sum > signed'(36'(ONE_Q30))) begin
            a_h_next = ONE_Q30;
        end else begin
            a_h_next = a_sum[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vh_reg <= 1'b0;
        else if (en) vh_reg <= vg_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_h_reg    <= a_h_next;
            dalt_h_reg <= dalt_g_reg;
        end
    end

    // ---------------- roots of a and 1-a ----------------
    logic [63:0] sq_in [2];
    logic [31:0] sq_out [2];
    logic        sq_valid;
    logic [31:0] sq_side;

    assign sq_in[0] = 64'(a_h_reg) << 30;
    assign sq_in[1] = 64'(ONE_Q30 - a_h_reg) << 30;

    gcd_isqrt #(
        .ROOT_W (32),
        .LANES  (2),
        .SIDE_W (32)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vh_reg),
        .in_side   (dalt_h_reg),
        .in_n      (sq_in),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (sq_out)
    );

    // ---------------- vectoring CORDIC: atan2(sqrt(a), sqrt(1-a)) ----------------
    logic signed [CW-1:0] vec_x_in [1], vec_y_in [1], vec_z_in [1], vec_z_out [1];
    logic                 vec_valid;
    logic [32:0]          vec_side;

    assign vec_x_in[0] = signed'(CW'(sq_out[1]));
    assign vec_y_in[0] = signed'(CW'(sq_out[0]));
    assign vec_z_in[0] = '0;

    gcd_cordic #(
        .STEPS  (CORDIC_STEPS),
        .LANES  (1),
        .SIDE_W (33)
    ) u_vec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .vec_mode  (1'b1),
        .in_valid  (sq_valid),
        .in_side   ({sq_side, sq_out[0] == 32'd0}),
        .in_x      (vec_x_in),
        .in_y      (vec_y_in),
        .in_z      (vec_z_in),
        .out_valid (vec_valid),
        .out_side  (vec_side),
        .out_x     (),
        .out_y     (),
        .out_z     (vec_z_out)
    );

    // ---------------- stage I: radius times central angle ----------------
    logic        vi_reg;
    logic [61:0] p_i_reg;
    logic [31:0] dalt_i_reg;
    logic [31:0] c_ang;

    // identical points or a negative residue give a zero angle
    assign c_ang = (vec_side[0] || vec_z_out[0][CW-1]) ? 32'd0 : {vec_z_out[0][30:0], 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) vi_reg <= 1'b0;
        else if (en) vi_reg <= vec_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_i_reg    <= 62'(radius_reg) * 62'(c_ang);
            dalt_i_reg <= vec_side[32:1];
        end
    end

    // ---------------- stage J: meters Q30 to whole millimeters ----------------
    logic        vj_reg;
    logic [41:0] dist_j_reg;
    logic [31:0] dalt_j_reg;
    logic [63:0] q_j, s_j;
    logic [43:0] d_j;

    always_comb begin
        q_j = 64'(p_i_reg[61:10]);
        // times 1000 as 1024 - 16 - 8
        s_j = (q_j << 10) - (q_j << 4) - (q_j << 3) + (64'd1 << 19);
        d_j = s_j[63:20];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vj_reg <= 1'b0;
        else if (en) vj_reg <= vi_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_j_reg <= (d_j > DIST_MAX) ? DIST_MAX[41:0] : d_j[41:0];
            dalt_j_reg <= dalt_i_reg;
        end
    end

    // ---------------- stage K: partial squares ----------------
    logic        vk_reg;
    logic [41:0] hh_k_reg, hl_k_reg, ll_k_reg;
    logic [63:0] dd_k_reg;
    logic [41:0] dist_k_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vk_reg <= 1'b0;
        else if (en) vk_reg <= vj_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hh_k_reg   <= 42'(dist_j_reg[41:21]) * 42'(dist_j_reg[41:21]);
            hl_k_reg   <= 42'(dist_j_reg[41:21]) * 42'(dist_j_reg[20:0]);
            ll_k_reg   <= 42'(dist_j_reg[20:0]) * 42'(dist_j_reg[20:0]);
            dd_k_reg   <= 64'(dalt_j_reg) * 64'(dalt_j_reg);
            dist_k_reg <= dist_j_reg;
        end
    end

    // ---------------- stage L: sum of squares ----------------
    logic        vl_reg;
    logic [87:0] n_l_reg;
    logic [41:0] dist_l_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vl_reg <= 1'b0;
        else if (en) vl_reg <= vk_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_l_reg    <= (88'(hh_k_reg) << 42) + (88'(hl_k_reg) << 22)
                        + 88'(ll_k_reg) + 88'(dd_k_reg);
            dist_l_reg <= dist_k_reg;
        end
    end

    // ---------------- altitude root ----------------
    logic [87:0] hyp_in [1];
    logic [43:0] hyp_out [1];
    logic        hyp_valid;
    logic [41:0] hyp_dist;
    logic [41:0] result;

    assign hyp_in[0] = n_l_reg;

    gcd_isqrt #(
        .ROOT_W (44),
        .LANES  (1),
        .SIDE_W (42)
    ) u_hyp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vl_reg),
        .in_side   (dist_l_reg),
        .in_n      (hyp_in),
        .out_valid (hyp_valid),
        .out_side  (hyp_dist),
        .out_root  (hyp_out)
    );

    always_comb begin
        if (!incl_alt_reg) begin
            result = hyp_dist;
        end else if (hyp_out[0] > DIST_MAX) begin
            result = DIST_MAX[41:0];
        end else begin
            result = hyp_out[0][41:0];
        end
    end

    // ---------------- output register and skid ----------------
    logic out_take;
    assign out_take = m_valid_reg && m_ready;

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_dist_next     = m_dist_reg;
        skid_valid_next = skid_valid_reg;
        skid_dist_next  = skid_dist_reg;
        if (skid_valid_reg) begin
            // pipeline is frozen; drain the parked item first
            if (out_take) begin
                m_dist_next     = skid_dist_reg;
                skid_valid_next = 1'b0;
            end
        end else if (!m_valid_reg || out_take) begin
            m_valid_next = hyp_valid;
            m_dist_next  = result;
        end else if (hyp_valid) begin
            skid_valid_next = 1'b1;
            skid_dist_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_dist_reg    <= m_dist_next;
        skid_dist_reg <= skid_dist_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_distance_mm = m_dist_reg;

    // ---------------- assertions ----------------
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid holds an item while output is empty");

    a_out_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (44'(m_dist_reg) <= DIST_MAX))
        else $error("distance above saturation limit");

    a_skid_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && hyp_valid && !skid_valid_reg) |=> skid_valid_reg)
        else $error("stalled result dropped instead of parked");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_ready) |=> (!skid_valid_reg && m_valid_reg))
        else $error("parked item not moved to output");

endmodule
